@@ rtl/ppcbr_pkg.sv @@
// Shared function codes and branch-option bit positions for the PowerPC branch and CR unit.
package ppcbr_pkg;

  typedef enum logic [3:0] {
    FUNC_B     = 4'd0,
    FUNC_BC    = 4'd1,
    FUNC_BCCTR = 4'd2,
    FUNC_BCLR  = 4'd3,
    FUNC_AND   = 4'd4,
    FUNC_ANDC  = 4'd5,
    FUNC_EQV   = 4'd6,
    FUNC_NAND  = 4'd7,
    FUNC_NOR   = 4'd8,
    FUNC_OR    = 4'd9,
    FUNC_ORC   = 4'd10,
    FUNC_XOR   = 4'd11,
    FUNC_MCRF  = 4'd12
  } func_e;

  // Bit positions within the five-bit BO field.
  localparam int unsigned BoNoCond = 4;
  localparam int unsigned BoSense  = 3;
  localparam int unsigned BoNoCtr  = 2;
  localparam int unsigned BoCtrEqz = 1;

  localparam logic [63:0] WordBytes = 64'd4;

endpackage

@@ rtl/ppc_branch_cr_unit.sv @@
// PowerPC branch and condition-register unit: input register, one resolve step, result register.
// A beat accepted into the input register is resolved from it and moves on to the result
// register when that is free. Throughput: one instruction per cycle while the result side
// does not stall; the only path is the input register, the branch resolve logic (two 64-bit
// adds and one 64-bit decrement with a zero test, side by side) and the result register.
// Reset: rst_ni clears both stage valid flags asynchronously; the payload registers are not
// reset. No state survives between instructions.
module ppc_branch_cr_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [63:0] insn_address_i,
  input  logic        link_i,
  input  logic        absolute_i,
  input  logic signed [23:0] displacement_i,
  input  logic [4:0]  bo_field_i,
  input  logic [4:0]  bit_a_i,
  input  logic [4:0]  bit_b_i,
  input  logic [4:0]  bit_d_i,
  input  logic [63:0] lr_in_i,
  input  logic [63:0] ctr_in_i,
  input  logic [31:0] cr_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] next_address_o,
  output logic        taken_o,
  output logic [63:0] lr_out_o,
  output logic [63:0] ctr_out_o,
  output logic [31:0] cr_out_o
);
  import ppcbr_pkg::*;

  // Stage one holds the decoded instruction, stage two holds the finished result.
  logic        s1_valid_q, s2_valid_q;
  logic        s1_load, s2_load, s2_ready;

  logic [3:0]  func_q;
  logic [63:0] addr_q;
  logic        link_q, abs_q;
  logic [23:0] disp_q;
  logic [4:0]  bo_q, ba_q, bb_q, bd_q;
  logic [63:0] lr_q, ctr_q;
  logic [31:0] cr_q;

  logic [63:0] next_d, lr_d, ctr_d;
  logic        taken_d;
  logic [31:0] cr_d;

  logic [63:0] next_q, lr_out_q, ctr_out_q;
  logic        taken_q;
  logic [31:0] cr_out_q;

  // The result register frees up when it is empty or its beat is being taken this cycle.
  // Stage one then moves forward, so a new beat can enter behind it in the same cycle.
  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign s2_load    = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      func_q <= func_i;
      addr_q <= insn_address_i;
      link_q <= link_i;
      abs_q  <= absolute_i;
      disp_q <= displacement_i;
      bo_q   <= bo_field_i;
      ba_q   <= bit_a_i;
      bb_q   <= bit_b_i;
      bd_q   <= bit_d_i;
      lr_q   <= lr_in_i;
      ctr_q  <= ctr_in_i;
      cr_q   <= cr_in_i;
    end
  end

  // Resolve logic. CR bit 0 is the most significant, so bit index i lives at cr[~i],
  // and field f occupies the nibble starting at {~f, 2'b00}.
  logic [63:0] ret_addr, disp_ext, rel_target, imm_target, ctr_dec;
  logic        bit_a_val, bit_b_val, cond_ok, ctr_ok, is_branch, logic_v;
  logic [3:0]  src_field;
  logic [2:0]  fs, fd;

  always_comb begin
    ret_addr   = addr_q + WordBytes;
    disp_ext   = {{38{disp_q[23]}}, disp_q, 2'b00};
    rel_target = addr_q + disp_ext;
    imm_target = (abs_q ? disp_ext : rel_target) & ~64'h3;
    ctr_dec    = ctr_q - 64'd1;
    bit_a_val  = cr_q[~ba_q];
    bit_b_val  = cr_q[~bb_q];
    cond_ok    = bo_q[BoNoCond] || (bit_a_val == bo_q[BoSense]);
    // The count test looks at the decremented value; with no decrement it always passes.
    ctr_ok     = bo_q[BoNoCtr] || ((ctr_dec != 64'd0) != bo_q[BoCtrEqz]);
    fs         = ba_q[4:2];
    fd         = bd_q[4:2];
    src_field  = cr_q[{~fs, 2'b00} +: 4];

    next_d    = ret_addr;
    taken_d   = 1'b0;
    lr_d      = lr_q;
    ctr_d     = ctr_q;
    cr_d      = cr_q;
    is_branch = 1'b0;
    logic_v   = 1'b0;

    unique case (func_q)
      FUNC_B: begin
        is_branch = 1'b1;
        taken_d   = 1'b1;
        next_d    = imm_target;
      end
      FUNC_BC, FUNC_BCLR: begin
        is_branch = 1'b1;
        if (!bo_q[BoNoCtr]) begin
          ctr_d = ctr_dec;
        end
        if (ctr_ok && cond_ok) begin
          taken_d = 1'b1;
          next_d  = (func_q == FUNC_BC) ? imm_target : (lr_q & ~64'h3);
        end
      end
      FUNC_BCCTR: begin
        is_branch = 1'b1;
        if (cond_ok) begin
          taken_d = 1'b1;
          next_d  = ctr_q & ~64'h3;
        end
      end
      FUNC_AND, FUNC_ANDC, FUNC_EQV, FUNC_NAND,
      FUNC_NOR, FUNC_OR, FUNC_ORC, FUNC_XOR: begin
        unique case (func_q)
          FUNC_AND:  logic_v = bit_a_val & bit_b_val;
          FUNC_ANDC: logic_v = bit_a_val & ~bit_b_val;
          FUNC_EQV:  logic_v = ~(bit_a_val ^ bit_b_val);
          FUNC_NAND: logic_v = ~(bit_a_val & bit_b_val);
          FUNC_NOR:  logic_v = ~(bit_a_val | bit_b_val);
          FUNC_OR:   logic_v = bit_a_val | bit_b_val;
          FUNC_ORC:  logic_v = bit_a_val | ~bit_b_val;
          default:   logic_v = bit_a_val ^ bit_b_val;
        endcase
        cr_d[~bd_q] = logic_v;
      end
      FUNC_MCRF: begin
        cr_d[{~fd, 2'b00} +: 4] = src_field;
      end
      default: begin
        // Unassigned codes fall through with nothing changed.
      end
    endcase

    // The return address goes into LR only for a taken branch with LK set.
    if (is_branch && taken_d && link_q) begin
      lr_d = ret_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      next_q    <= next_d;
      taken_q   <= taken_d;
      lr_out_q  <= lr_d;
      ctr_out_q <= ctr_d;
      cr_out_q  <= cr_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign next_address_o = next_q;
  assign taken_o        = taken_q;
  assign lr_out_o       = lr_out_q;
  assign ctr_out_o      = ctr_out_q;
  assign cr_out_o       = cr_out_q;

`ifndef SYNTHESIS
  // The input side only stalls while stage one holds a beat it cannot pass on.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled without a blocked beat in stage one");

  // A beat held in stage one keeps its contents.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (s1_valid_q && $stable(func_q) && $stable(addr_q) && $stable(ctr_q)))
    else $error("stage one lost or changed a stalled beat");

  // Non-branch operations never redirect and never touch LR or CTR.
  a_non_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !is_branch) |->
      (!taken_d && (lr_d == lr_q) && (ctr_d == ctr_q) && (next_d == ret_addr)))
    else $error("non-branch operation changed control flow state");

  // A taken branch always lands on a word boundary.
  a_taken_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && taken_d) |-> (next_d[1:0] == 2'b00))
    else $error("taken branch target not word aligned");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the PowerPC branch and condition-register unit.
`timescale 1ns / 100ps

module testbench;
  import ppcbr_pkg::*;

  // One instruction as offered on the input channel. The drain flag is not a port: it asks the
  // driver to hold this beat back until every outstanding result has come out.
  typedef struct packed {
    logic [3:0]  func;
    logic [63:0] addr;
    logic        link;
    logic        absolute;
    logic [23:0] disp;
    logic [4:0]  bo;
    logic [4:0]  bit_a;
    logic [4:0]  bit_b;
    logic [4:0]  bit_d;
    logic [63:0] lr;
    logic [63:0] ctr;
    logic [31:0] cr;
    logic        wait_drain;
  } insn_t;

  // Architectural outcome of one instruction, in the order of the result ports.
  typedef struct packed {
    logic [63:0] next_addr;
    logic        taken;
    logic [63:0] lr;
    logic [63:0] ctr;
    logic [31:0] cr;
  } outcome_t;

  localparam logic [63:0] AlignMask  = ~64'h3;
  localparam int unsigned IdlePct    = 28;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumRandom  = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel. All payload ports follow the beat register through continuous assigns,
  // so each port is known from time zero.
  insn_t       in_beat = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_beat_done = 1'b0;

  // Result channel.
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] next_address;
  logic        taken;
  logic [63:0] lr_out;
  logic [63:0] ctr_out;
  logic [31:0] cr_out;

  insn_t       pending_q[$];
  outcome_t    outcome_q[$];
  outcome_t    got_outcome;
  outcome_t    want_outcome;

  int unsigned n_in_beats = 0;
  int unsigned n_results = 0;
  int unsigned n_taken = 0;
  int unsigned n_mismatch = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // A window in the middle of the random part where neither side idles, so that the block
  // sees back-to-back beats at full rate.
  assign calm = (n_in_beats >= 300) && (n_in_beats < 380);

  ppc_branch_cr_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (in_beat.func),
    .insn_address_i (in_beat.addr),
    .link_i         (in_beat.link),
    .absolute_i     (in_beat.absolute),
    .displacement_i (in_beat.disp),
    .bo_field_i     (in_beat.bo),
    .bit_a_i        (in_beat.bit_a),
    .bit_b_i        (in_beat.bit_b),
    .bit_d_i        (in_beat.bit_d),
    .lr_in_i        (in_beat.lr),
    .ctr_in_i       (in_beat.ctr),
    .cr_in_i        (in_beat.cr),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .next_address_o (next_address),
    .taken_o        (taken),
    .lr_out_o       (lr_out),
    .ctr_out_o      (ctr_out),
    .cr_out_o       (cr_out)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Works out what the unit must return for one instruction. CR bit 0 is the most significant
  // bit, so CR bit i lives at vector position 31 - i.
  function automatic outcome_t resolve_branch(insn_t t);
    outcome_t    r;
    logic [63:0] ret_addr;
    logic [63:0] disp_bytes;
    logic [63:0] imm_target;
    logic [63:0] ctr_next;
    logic        cond_ok;
    logic        ctr_ok;
    logic        a;
    logic        b;
    logic        v;
    logic [3:0]  field;
    int          src_pos;
    int          dst_pos;
    ret_addr    = t.addr + WordBytes;
    r.next_addr = ret_addr;
    r.taken     = 1'b0;
    r.lr        = t.lr;
    r.ctr       = t.ctr;
    r.cr        = t.cr;
    // The word offset is sign-extended and turned into a byte offset; sums wrap at 64 bits.
    disp_bytes  = {{38{t.disp[23]}}, t.disp, 2'b00};
    imm_target  = (t.absolute ? disp_bytes : t.addr + disp_bytes) & AlignMask;
    cond_ok     = t.bo[BoNoCond] || (t.cr[31 - int'(t.bit_a)] == t.bo[BoSense]);
    a           = t.cr[31 - int'(t.bit_a)];
    b           = t.cr[31 - int'(t.bit_b)];
    v           = 1'b0;
    case (t.func)
      FUNC_B: begin
        // The unconditional form ignores BO and BI altogether.
        r.taken     = 1'b1;
        r.next_addr = imm_target;
      end
      FUNC_BC, FUNC_BCLR: begin
        // Unless the no-decrement bit of BO is set, the counter is decremented whether or not the branch goes.
        ctr_next = t.bo[BoNoCtr] ? t.ctr : t.ctr - 64'd1;
        r.ctr    = ctr_next;
        ctr_ok   = t.bo[BoNoCtr] || ((ctr_next != 64'd0) != t.bo[BoCtrEqz]);
        if (ctr_ok && cond_ok) begin
          r.taken     = 1'b1;
          r.next_addr = (t.func == FUNC_BC) ? imm_target : (t.lr & AlignMask);
        end
      end
      FUNC_BCCTR: begin
        // The counter is neither decremented nor tested here; it is only the target.
        if (cond_ok) begin
          r.taken     = 1'b1;
          r.next_addr = t.ctr & AlignMask;
        end
      end
      FUNC_AND:  v = a & b;
      FUNC_ANDC: v = a & ~b;
      FUNC_EQV:  v = ~(a ^ b);
      FUNC_NAND: v = ~(a & b);
      FUNC_NOR:  v = ~(a | b);
      FUNC_OR:   v = a | b;
      FUNC_ORC:  v = a | ~b;
      FUNC_XOR:  v = a ^ b;
      FUNC_MCRF: begin
        src_pos = 31 - 4 * int'(t.bit_a[4:2]);
        dst_pos = 31 - 4 * int'(t.bit_d[4:2]);
        field   = t.cr[src_pos -: 4];
        r.cr[dst_pos -: 4] = field;
      end
      default: ;
    endcase
    if (t.func >= FUNC_AND && t.func <= FUNC_XOR) begin
      r.cr[31 - int'(t.bit_d)] = v;
    end
    // The return address is the full 64-bit sum, for bclr as for the other branches.
    if (r.taken && t.link && t.func <= FUNC_BCLR) begin
      r.lr = ret_addr;
    end
    return r;
  endfunction

  // Register values that favour the corners: zero, all ones and values close to either.
  function automatic logic [63:0] wide_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'($urandom_range(0, 7));
      3: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic insn_t rand_insn(logic [3:0] f);
    insn_t t;
    t.func     = f;
    t.addr     = wide_value();
    t.link     = 1'($urandom_range(0, 1));
    t.absolute = 1'($urandom_range(0, 1));
    t.disp     = 24'($urandom);
    t.bo       = 5'($urandom);
    t.bit_a    = 5'($urandom);
    t.bit_b    = 5'($urandom);
    t.bit_d    = 5'($urandom);
    t.lr       = wide_value();
    // Small counts make the decrement-and-test outcome go both ways often.
    t.ctr      = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 2)) : wide_value();
    case ($urandom_range(0, 5))
      0: t.cr = 32'd0;
      1: t.cr = '1;
      default: t.cr = $urandom;
    endcase
    t.wait_drain = 1'b0;
    return t;
  endfunction

  // Driver: a new beat is chosen at the falling edge only once the current one has been
  // accepted, so a stalled beat keeps its payload and its valid.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_beat_done) begin
        if (pending_q.size() != 0 &&
            !(pending_q[0].wait_drain && outcome_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_beat  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once enough beats have gone in, during
  // which the sender keeps offering so that the pipeline fills and pushes back.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_in_beats >= 100) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Monitor and scoreboard. Results are checked before the new expectation is queued, so a
  // result and an input beat on the same edge never depend on process order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results++;
        got_outcome = '{next_addr: next_address, taken: taken, lr: lr_out,
                        ctr: ctr_out, cr: cr_out};
        if (got_outcome.taken === 1'b1) begin
          n_taken++;
        end
        if (outcome_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MaxReports) begin
            $display("unexpected result beat: next %h taken %b lr %h ctr %h cr %h",
                     next_address, taken, lr_out, ctr_out, cr_out);
          end
        end else begin
          want_outcome = outcome_q.pop_front();
          if (got_outcome !== want_outcome) begin
            n_mismatch++;
            if (n_mismatch <= MaxReports) begin
              $display("result %0d mismatch (expected / actual):", n_results);
              $display("  next %h / %h  taken %b / %b", want_outcome.next_addr,
                       got_outcome.next_addr, want_outcome.taken, got_outcome.taken);
              $display("  lr %h / %h  ctr %h / %h  cr %h / %h", want_outcome.lr,
                       got_outcome.lr, want_outcome.ctr, got_outcome.ctr,
                       want_outcome.cr, got_outcome.cr);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        outcome_q.push_back(resolve_branch(in_beat));
        n_in_beats++;
      end
      in_beat_done <= in_valid && !in_stall;
      // Watchdog on cycles in which neither channel moves a beat.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("no beat moved for %0d cycles", StuckLimit);
        $display("FAIL ppc_branch_cr_unit");
        $finish;
      end
    end
  end

  initial begin
    insn_t t;
    int    r;

    // Directed part: target extremes and address wrap for the plain branch.
    t = rand_insn(FUNC_B); t.absolute = 1'b0; t.disp = 24'h7F_FFFF; t.link = 1'b1;
    pending_q.push_back(t);
    t = rand_insn(FUNC_B); t.absolute = 1'b0; t.disp = 24'h80_0000; t.addr = 64'h10;
    pending_q.push_back(t);
    t = rand_insn(FUNC_B); t.absolute = 1'b1; t.disp = 24'h80_0000; t.link = 1'b0;
    pending_q.push_back(t);
    t = rand_insn(FUNC_B); t.absolute = 1'b0; t.disp = 24'd1;
    t.addr = 64'hFFFF_FFFF_FFFF_FFFC; t.link = 1'b1;
    pending_q.push_back(t);
    // Conditional branch: each arm of the counter and condition tests.
    t = rand_insn(FUNC_BC); t.bo = 5'h14; pending_q.push_back(t);
    t = rand_insn(FUNC_BC); t.bo = 5'h00; t.ctr = 64'd1; pending_q.push_back(t);
    t = rand_insn(FUNC_BC); t.bo = 5'h12; t.ctr = 64'd1; pending_q.push_back(t);
    t = rand_insn(FUNC_BC); t.bo = 5'h10; t.ctr = 64'd0; t.link = 1'b1;
    pending_q.push_back(t);
    t = rand_insn(FUNC_BC); t.bo = 5'h0C; t.cr = '1; t.bit_a = 5'd31; t.absolute = 1'b1;
    pending_q.push_back(t);
    t = rand_insn(FUNC_BC); t.bo = 5'h04; t.cr = 32'd0; t.bit_a = 5'd0;
    pending_q.push_back(t);
    // Counter branch: the counter bits in BO must have no effect.
    t = rand_insn(FUNC_BCCTR); t.bo = 5'h14; t.link = 1'b1; t.ctr = '1;
    pending_q.push_back(t);
    t = rand_insn(FUNC_BCCTR); t.bo = 5'h02; t.ctr = 64'd0; pending_q.push_back(t);
    // Link-register branch: the return address must keep all 64 bits.
    t = rand_insn(FUNC_BCLR); t.bo = 5'h14; t.link = 1'b1;
    t.addr = 64'hFEDC_BA98_7654_3210; t.lr = 64'h8000_0001_0000_0007;
    pending_q.push_back(t);
    t = rand_insn(FUNC_BCLR); t.bo = 5'h00; t.ctr = 64'd2; pending_q.push_back(t);
    // Every CR logical operation, with the outermost bit indices.
    for (int f = FUNC_AND; f <= FUNC_XOR; f++) begin
      t = rand_insn(4'(f));
      t.bit_a = (f % 2 == 0) ? 5'd0 : 5'd31;
      t.bit_b = (f % 2 == 0) ? 5'd31 : 5'd0;
      t.bit_d = (f % 4 < 2) ? 5'd0 : 5'd31;
      pending_q.push_back(t);
    end
    // Field moves between the outermost CR fields.
    t = rand_insn(FUNC_MCRF); t.bit_a = 5'd0; t.bit_d = 5'd31; pending_q.push_back(t);
    t = rand_insn(FUNC_MCRF); t.bit_a = 5'd31; t.bit_d = 5'd0; pending_q.push_back(t);
    // Unused function codes behave as no-ops.
    for (int f = 13; f <= 15; f++) begin
      pending_q.push_back(rand_insn(4'(f)));
    end

    // Random part: mostly branches, where the interesting corners are.
    for (int i = 0; i < NumRandom; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        t = rand_insn(4'($urandom_range(FUNC_B, FUNC_BCLR)));
      end else if (r < 95) begin
        t = rand_insn(4'($urandom_range(FUNC_AND, FUNC_MCRF)));
      end else begin
        t = rand_insn(4'($urandom_range(13, 15)));
      end
      // Twice the sender pauses until the pipeline has emptied completely.
      t.wait_drain = (i == 200) || (i == 450);
      pending_q.push_back(t);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Stop once every instruction is in and every result is out, then keep watching the result
    // port so that any stray result beat is caught.
    while (pending_q.size() != 0 || in_valid || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    $display("Resolved %0d instructions, %0d results checked, %0d branches taken,",
             n_in_beats, n_results, n_taken);
    $display("with random stalls, one long receiver hold-off and two full drains; %0d bad.",
             n_mismatch);
    if (n_mismatch == 0 && outcome_q.size() == 0) begin
      $display("PASS ppc_branch_cr_unit");
    end else begin
      $display("FAIL ppc_branch_cr_unit");
    end
    $finish;
  end

endmodule
